// ===== sv/pwq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pwq_pkg;

   localparam int ID_BITS          = 8;
   localparam int PRIO_BITS        = 8;
   localparam int MAX_WAITERS_DEF  = 16;
   localparam int ENTRY_W          = ID_BITS + PRIO_BITS;
   localparam int OCC_W            = 5;
   localparam int REQ_DATA_W       = 16;
   localparam int RSP_DATA_W       = 24;

   typedef enum logic {
      FUNC_INSERT = 1'b0,
      FUNC_REMOVE = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_FULL      = 2'd1,
      STAT_NOT_FOUND = 2'd2,
      STAT_DUP       = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_DECIDE,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_PLACE,
      S_RESP
   } state_type;

endpackage

`default_nettype wire

// ===== sv/priority_wait_queue_core.sv =====
// Sorted wait queue of thread ids, smaller priority first, equal priorities
// kept in arrival order.
// Request channel (req_*): one transaction per operation. req_tuser selects
// insert (0) or remove by id (1); req_tdata carries the thread id and the
// priority of an inserted waiter.
// Response channel (rsp_*): exactly one transaction per request, carrying the
// status, the head entry after the operation and the occupancy.
// The entries live in one small memory; a sequencer walks it with one shared
// compare unit. Each visited entry is read and then compared; each moved entry
// is read and then written back one slot over.
// After acceptance the core scans every occupied entry, decides, shifts the
// entries that move and writes an inserted entry before it loads the response;
// on an empty queue the scan is skipped.
// One operation is processed at a time; req_tready is high only while idle, so
// a new request is taken only once the previous response has been loaded.
// The response sits in an output register; a stalled receiver holds the core
// at its response step until the register frees up.
// Reset empties the queue and drops any pending response.
`timescale 1ns / 1ps
`default_nettype none

module priority_wait_queue_core #(
   parameter int MAX_WAITERS = pwq_pkg::MAX_WAITERS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // thread_id [7:0], priority_req [15:8]
   input  wire logic [pwq_pkg::REQ_DATA_W-1:0]  req_tdata,
   // func
   input  wire logic                            req_tuser,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // status [1:0], head_valid [2], head_thread [10:3], head_priority [18:11],
   // occupancy [23:19]
   output logic [pwq_pkg::RSP_DATA_W-1:0]       rsp_tdata
);

   import pwq_pkg::*;

   localparam int CNT_W = $clog2(MAX_WAITERS + 1);
   localparam int IDX_W = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;

   logic [ENTRY_W-1:0] slot_mem [MAX_WAITERS];
   logic [ENTRY_W-1:0] slot_rd_ff;

   state_type                state_ff, state_in;
   func_type                 func_ff, func_in;
   logic [ID_BITS-1:0]       id_ff, id_in;
   logic [PRIO_BITS-1:0]     prio_ff, prio_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic                     found_ff, found_in;
   logic [IDX_W-1:0]         hit_ff, hit_in;
   logic                     pos_set_ff, pos_set_in;
   logic [CNT_W-1:0]         pos_ff, pos_in;
   logic [CNT_W-1:0]         cur_ff, cur_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   status_type               status_ff, status_in;
   logic [ID_BITS-1:0]       head_thread_ff;
   logic [PRIO_BITS-1:0]     head_prio_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]    rsp_data_ff, rsp_data_in;

   logic                     rsp_load;
   logic                     wr_en;
   logic [IDX_W-1:0]         wr_addr;
   logic [ENTRY_W-1:0]       wr_data;
   logic [IDX_W-1:0]         rd_addr;

   logic [ID_BITS-1:0]       rd_thread;
   logic [PRIO_BITS-1:0]     rd_prio;
   logic                     id_match;
   logic                     prio_greater;
   logic                     scan_last;
   logic                     count_full;
   logic [CNT_W-1:0]         hit_ext;
   logic                     head_valid;

   // shared compare unit
   assign rd_thread    = slot_rd_ff[ID_BITS-1:0];
   assign rd_prio      = slot_rd_ff[ENTRY_W-1:ID_BITS];
   assign id_match     = (rd_thread == id_ff);
   assign prio_greater = (rd_prio > prio_ff);
   assign scan_last    = ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff);
   assign count_full   = (count_ff == CNT_W'(MAX_WAITERS));
   assign hit_ext      = CNT_W'(hit_ff);
   assign rsp_load     = (state_ff == S_RESP) && (!rsp_valid_ff || rsp_tready);
   assign head_valid   = (count_ff != '0);

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = (count_ff == '0) ? S_DECIDE : S_SCAN_RD;
            end
         end
         S_SCAN_RD: begin
            state_in = S_SCAN_CHK;
         end
         S_SCAN_CHK: begin
            state_in = scan_last ? S_DECIDE : S_SCAN_RD;
         end
         S_DECIDE: begin
            if (func_ff == FUNC_INSERT) begin
               if (found_ff || count_full) begin
                  state_in = S_RESP;
               end else if (count_ff == pos_ff) begin
                  state_in = S_PLACE;
               end else begin
                  state_in = S_SHIFT_RD;
               end
            end else begin
               if (!found_ff || ((hit_ext + CNT_W'(1)) == count_ff)) begin
                  state_in = S_RESP;
               end else begin
                  state_in = S_SHIFT_RD;
               end
            end
         end
         S_SHIFT_RD: begin
            state_in = S_SHIFT_WR;
         end
         S_SHIFT_WR: begin
            if (func_ff == FUNC_INSERT) begin
               state_in = ((cur_ff - CNT_W'(1)) == pos_ff) ? S_PLACE : S_SHIFT_RD;
            end else begin
               state_in = ((cur_ff + CNT_W'(2)) == count_ff) ? S_RESP : S_SHIFT_RD;
            end
         end
         S_PLACE: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // datapath next values
   always_comb begin
      func_in    = func_ff;
      id_in      = id_ff;
      prio_in    = prio_ff;
      idx_in     = idx_ff;
      found_in   = found_ff;
      hit_in     = hit_ff;
      pos_set_in = pos_set_ff;
      pos_in     = pos_ff;
      cur_in     = cur_ff;
      count_in   = count_ff;
      status_in  = status_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               func_in    = func_type'(req_tuser);
               id_in      = req_tdata[ID_BITS-1:0];
               prio_in    = req_tdata[ID_BITS +: PRIO_BITS];
               idx_in     = '0;
               found_in   = 1'b0;
               pos_set_in = 1'b0;
               pos_in     = count_ff;
            end
         end
         S_SCAN_CHK: begin
            if (id_match && !found_ff) begin
               found_in = 1'b1;
               hit_in   = idx_ff;
            end
            if ((func_ff == FUNC_INSERT) && prio_greater && !pos_set_ff) begin
               pos_set_in = 1'b1;
               pos_in     = CNT_W'(idx_ff);
            end
            if (!scan_last) begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         S_DECIDE: begin
            if (func_ff == FUNC_INSERT) begin
               if (found_ff) begin
                  status_in = STAT_DUP;
               end else if (count_full) begin
                  status_in = STAT_FULL;
               end else begin
                  status_in = STAT_OK;
                  cur_in    = count_ff;
               end
            end else begin
               if (!found_ff) begin
                  status_in = STAT_NOT_FOUND;
               end else begin
                  status_in = STAT_OK;
                  cur_in    = hit_ext;
                  if ((hit_ext + CNT_W'(1)) == count_ff) begin
                     count_in = count_ff - CNT_W'(1);
                  end
               end
            end
         end
         S_SHIFT_WR: begin
            if (func_ff == FUNC_INSERT) begin
               cur_in = cur_ff - CNT_W'(1);
            end else begin
               cur_in = cur_ff + CNT_W'(1);
               if ((cur_ff + CNT_W'(2)) == count_ff) begin
                  count_in = count_ff - CNT_W'(1);
               end
            end
         end
         S_PLACE: begin
            count_in = count_ff + CNT_W'(1);
         end
         default: begin
         end
      endcase
   end

   // memory control and response register
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = cur_ff[IDX_W-1:0];
      wr_data = slot_rd_ff;
      rd_addr = idx_ff;
      unique case (state_ff)
         S_SHIFT_RD: begin
            if (func_ff == FUNC_INSERT) begin
               rd_addr = IDX_W'(cur_ff - CNT_W'(1));
            end else begin
               rd_addr = IDX_W'(cur_ff + CNT_W'(1));
            end
         end
         S_SHIFT_WR: begin
            wr_en = 1'b1;
         end
         S_PLACE: begin
            wr_en   = 1'b1;
            wr_addr = pos_ff[IDX_W-1:0];
            wr_data = {prio_ff, id_ff};
         end
         default: begin
         end
      endcase

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {OCC_W'(count_ff),
                         head_valid ? head_prio_ff : PRIO_BITS'(0),
                         head_valid ? head_thread_ff : ID_BITS'(0),
                         head_valid,
                         status_ff};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_data;
      end
      slot_rd_ff <= slot_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == '0)) begin
         head_thread_ff <= wr_data[ID_BITS-1:0];
         head_prio_ff   <= wr_data[ENTRY_W-1:ID_BITS];
      end
      func_ff     <= func_in;
      id_ff       <= id_in;
      prio_ff     <= prio_in;
      idx_ff      <= idx_in;
      found_ff    <= found_in;
      hit_ff      <= hit_in;
      pos_set_ff  <= pos_set_in;
      pos_ff      <= pos_in;
      cur_ff      <= cur_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== test/priority_wait_queue_core_test.sv =====
`timescale 1ns / 1ps

module priority_wait_queue_core_test;
   import pwq_pkg::*;

   localparam int QUEUE_DEPTH = MAX_WAITERS_DEF;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_CYCLES = 100;

   typedef struct packed {
      logic [OCC_W-1:0]     occupancy;
      logic [PRIO_BITS-1:0] head_priority;
      logic [ID_BITS-1:0]   head_thread;
      logic                 head_valid;
      status_type           status;
   } wait_result_type;

   typedef struct {
      func_type             op;
      logic [ID_BITS-1:0]   id;
      logic [PRIO_BITS-1:0] prio;
   } wait_request_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;  // thread_id, priority_req
   logic                  req_tuser = 1'b0;  // func
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // status, head_valid, head_thread, head_priority, occupancy
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // predictor state
   logic [ID_BITS-1:0]    waiter_id[QUEUE_DEPTH];
   logic [PRIO_BITS-1:0]  waiter_prio[QUEUE_DEPTH];
   int                    waiter_total = 0;

   wait_request_type      queued_ops[$];
   wait_result_type       awaited_results[$];
   logic [ID_BITS-1:0]    gen_members[$];
   wait_request_type      next_op;
   wait_result_type       seen_result;
   wait_result_type       want_result;
   int                    ops_in_flight = 0;
   int                    error_count = 0;
   int                    cycle_count = 0;
   int                    send_idle_pct = 0;
   int                    rsp_stall_pct = 0;
   logic                  req_fire = 1'b0;

   priority_wait_queue_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic wait_result_type apply_wait_op(func_type op, logic [ID_BITS-1:0] id,
                                                     logic [PRIO_BITS-1:0] prio);
      wait_result_type r;
      int found;
      int pos;
      found = -1;
      pos = 0;
      for (int i = 0; i < waiter_total; i++) begin
         if (found < 0 && waiter_id[i] == id) found = i;
      end
      if (op == FUNC_INSERT) begin
         if (found >= 0) begin
            r.status = STAT_DUP;
         end else if (waiter_total >= QUEUE_DEPTH) begin
            r.status = STAT_FULL;
         end else begin
            while (pos < waiter_total && waiter_prio[pos] <= prio) pos++;
            for (int i = waiter_total; i > pos; i--) begin
               waiter_id[i] = waiter_id[i-1];
               waiter_prio[i] = waiter_prio[i-1];
            end
            waiter_id[pos] = id;
            waiter_prio[pos] = prio;
            waiter_total++;
            r.status = STAT_OK;
         end
      end else begin
         if (found < 0) begin
            r.status = STAT_NOT_FOUND;
         end else begin
            for (int i = found; i + 1 < waiter_total; i++) begin
               waiter_id[i] = waiter_id[i+1];
               waiter_prio[i] = waiter_prio[i+1];
            end
            waiter_total--;
            r.status = STAT_OK;
         end
      end
      r.head_valid = (waiter_total > 0);
      r.head_thread = (waiter_total > 0) ? waiter_id[0] : '0;
      r.head_priority = (waiter_total > 0) ? waiter_prio[0] : '0;
      r.occupancy = OCC_W'(waiter_total);
      return r;
   endfunction

   // membership tracking used only to steer the stimulus
   task automatic queue_op(func_type op, int id, int prio);
      wait_request_type item;
      int found;
      found = -1;
      item.op = op;
      item.id = ID_BITS'(id);
      item.prio = PRIO_BITS'(prio);
      queued_ops.push_back(item);
      ops_in_flight++;
      for (int i = 0; i < gen_members.size(); i++) begin
         if (found < 0 && gen_members[i] == item.id) found = i;
      end
      if (op == FUNC_INSERT && found < 0 && gen_members.size() < QUEUE_DEPTH)
         gen_members.push_back(item.id);
      else if (op == FUNC_REMOVE && found >= 0)
         gen_members.delete(found);
   endtask

   task automatic queue_random(int n);
      bit fill_mode;
      int id;
      int prio;
      fill_mode = 1'b1;
      for (int k = 0; k < n; k++) begin
         if (k % 40 == 0) fill_mode = $urandom_range(1);
         prio = ($urandom_range(1) == 1) ? $urandom_range(3) : $urandom_range(255);
         if ($urandom_range(99) < (fill_mode ? 75 : 25)) begin
            if (gen_members.size() != 0 && $urandom_range(99) < 15)
               id = gen_members[$urandom_range(gen_members.size() - 1)];
            else if ($urandom_range(99) < 40)
               id = $urandom_range(23);
            else
               id = $urandom_range(255);
            queue_op(FUNC_INSERT, id, prio);
         end else begin
            if (gen_members.size() != 0 && $urandom_range(99) < 80)
               id = gen_members[$urandom_range(gen_members.size() - 1)];
            else
               id = $urandom_range(255);
            queue_op(FUNC_REMOVE, id, prio);
         end
      end
   endtask

   task automatic run_phase(int idle_pct, int stall_pct, int n);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      queue_random(n);
      while (ops_in_flight != 0 || awaited_results.size() != 0) @(negedge clock);
   endtask

   task automatic check_field(string name, int expected_val, int actual_val);
      if (expected_val != actual_val) begin
         $error("%s: expected %0d, actual %0d", name, expected_val, actual_val);
         error_count++;
      end
   endtask

   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         if (!req_tvalid || req_fire) begin
            if (queued_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_op = queued_ops.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {next_op.prio, next_op.id};
               req_tuser <= next_op.op;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_fire <= 1'b0;
      end else if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         cycle_count <= cycle_count + 1;
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_results.size() == 0) begin
               $error("response transaction with no request outstanding");
               error_count++;
            end else begin
               seen_result = wait_result_type'(rsp_tdata);
               want_result = awaited_results.pop_front();
               check_field("status", want_result.status, seen_result.status);
               check_field("head_valid", want_result.head_valid, seen_result.head_valid);
               check_field("head_thread", want_result.head_thread, seen_result.head_thread);
               check_field("head_priority", want_result.head_priority,
                           seen_result.head_priority);
               check_field("occupancy", want_result.occupancy, seen_result.occupancy);
            end
         end
         if (req_tvalid && req_tready) begin
            awaited_results.push_back(apply_wait_op(func_type'(req_tuser),
                                                    req_tdata[ID_BITS-1:0],
                                                    req_tdata[ENTRY_W-1:ID_BITS]));
            ops_in_flight--;
         end
         req_fire <= req_tvalid && req_tready;
      end
   end

   initial begin
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // empty queue, extremes, ties, duplicate and absent ids
      queue_op(FUNC_REMOVE, 5, 0);
      queue_op(FUNC_INSERT, 0, 255);
      queue_op(FUNC_INSERT, 255, 0);
      queue_op(FUNC_INSERT, 10, 0);
      queue_op(FUNC_INSERT, 255, 3);
      queue_op(FUNC_REMOVE, 10, 255);
      queue_op(FUNC_REMOVE, 255, 0);
      queue_op(FUNC_REMOVE, 0, 0);
      // fill to capacity with tied priorities
      for (int i = 1; i <= QUEUE_DEPTH; i++) queue_op(FUNC_INSERT, i, (i % 4) * 85);
      queue_op(FUNC_INSERT, 200, 1);
      queue_op(FUNC_INSERT, 3, 0);
      queue_op(FUNC_REMOVE, 200, 0);

      run_phase(0, 0, 205);
      run_phase(48, 0, 206);
      run_phase(0, 48, 206);
      run_phase(19, 19, 206);

      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0 && awaited_results.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
